/* design/pn2ds_pkg.sv */
// Shared constants, gradient tables and types for the 2D Perlin noise core.
package pn2ds_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FREQ_W  = 24;
  localparam int unsigned RANGE_W = 16;
  localparam int unsigned NOISE_W = 16;
  localparam int unsigned CFG_DW  = 24;
  localparam int unsigned CFG_IW  = 2;

  localparam int unsigned GRAD_COUNT = 8;
  localparam int unsigned HASH_W     = $clog2(GRAD_COUNT);

  typedef enum logic [CFG_IW-1:0] {
    CFG_FREQUENCY = 2'd0,
    CFG_RANGE_MIN = 2'd1,
    CFG_RANGE_MAX = 2'd2
  } cfg_idx_e;

  localparam logic signed [RANGE_W-1:0] RANGE_MIN_RST = 16'sd0;
  localparam logic signed [RANGE_W-1:0] RANGE_MAX_RST = 16'sd128;

  localparam logic signed [NOISE_W-1:0] NOISE_MAX = 16'sh7FFF;
  localparam logic signed [NOISE_W-1:0] NOISE_MIN = 16'sh8000;

  // gradient set: four diagonals, then four axes
  localparam logic signed [1:0] GRAD_GX [GRAD_COUNT] = '{
    2'sb01, 2'sb11, 2'sb01, 2'sb11, 2'sb01, 2'sb11, 2'sb00, 2'sb00
  };
  localparam logic signed [1:0] GRAD_GY [GRAD_COUNT] = '{
    2'sb01, 2'sb01, 2'sb11, 2'sb11, 2'sb00, 2'sb00, 2'sb01, 2'sb11
  };

  // per-stage load enables for the fade pipeline
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } fade_en_t;

endpackage

/* design/pn2ds_fade.sv */
// Three-stage pipelined quintic fade 6t^5 - 15t^4 + 10t^3 in fixed point.
module pn2ds_fade #(
  parameter int unsigned FRAC_BITS = pn2ds_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  pn2ds_pkg::fade_en_t       en_i,
  input  logic [FRAC_BITS-1:0]      t_i,
  output logic signed [FRAC_BITS+1:0] fade_o
);
  import pn2ds_pkg::*;

  localparam int unsigned AW = FRAC_BITS + 5;
  localparam int unsigned MW = 2 * FRAC_BITS + 6;
  localparam logic signed [AW-1:0] FIFTEEN_A = AW'(15) <<< FRAC_BITS;
  localparam logic signed [AW-1:0] TEN_A     = AW'(10) <<< FRAC_BITS;

  // stage 2
  logic signed [AW-1:0]        a_d, a_q;
  logic [FRAC_BITS-1:0]        c_d, c_q, t2_q;
  logic signed [AW-1:0]        t_a;
  logic [2*FRAC_BITS-1:0]      tt;
  // stage 3
  logic signed [AW-1:0]        b_d, b_q;
  logic [FRAC_BITS-1:0]        d_d, d_q;
  logic signed [MW-1:0]        ta;
  logic [2*FRAC_BITS-1:0]      ct;
  // stage 4
  logic signed [FRAC_BITS+1:0] fade_d, fade_q;
  logic signed [MW-1:0]        db;

  always_comb begin
    t_a = $signed(AW'(t_i));
    a_d = (t_a <<< 2) + (t_a <<< 1) - FIFTEEN_A;
    tt  = t_i * t_i;
    c_d = tt[FRAC_BITS +: FRAC_BITS];
  end

  always_comb begin
    ta  = $signed({1'b0, t2_q}) * a_q;
    b_d = $signed(ta[FRAC_BITS +: AW]) + TEN_A;
    ct  = c_q * t2_q;
    d_d = ct[FRAC_BITS +: FRAC_BITS];
  end

  always_comb begin
    db     = $signed({1'b0, d_q}) * b_q;
    fade_d = $signed(db[FRAC_BITS +: FRAC_BITS+2]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      a_q  <= a_d;
      c_q  <= c_d;
      t2_q <= t_i;
    end
    if (en_i.s3) begin
      b_q <= b_d;
      d_q <= d_d;
    end
    if (en_i.s4) begin
      fade_q <= fade_d;
    end
  end

  assign fade_o = fade_q;

endmodule

/* design/perlin_noise_2d_scaled_core.sv */
// Top level of the pipelined 2D Perlin noise core with frequency and output range scaling.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | to core   | in_valid_i / in_stall_o   | coord_x_i, coord_y_i (Q16.16)
//  out     | from core | out_valid_o / out_stall_i | noise_value_o (signed 16 bits)
//  cfg     | to core   | cfg_we_i                  | cfg_index_i, cfg_data_i
//
//  Throughput one word per cycle while out_stall_i is low; the stage chain is
//  scale multiply, dots and fade, two lerp rows, range multiply, round, saturate.
//  rst_ni clears the stage valid bits and loads the register defaults
//  (frequency 1.0, range 0..128). Each stage loads when it is empty or the stage
//  after it moves, so bubbles close up and in_stall_o rises only when every
//  stage holds a word and the output is stalled.
module perlin_noise_2d_scaled_core #(
  parameter int unsigned FRAC_BITS = pn2ds_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // input words
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [pn2ds_pkg::COORD_W-1:0]   coord_x_i,
  input  logic signed [pn2ds_pkg::COORD_W-1:0]   coord_y_i,
  // result words
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pn2ds_pkg::NOISE_W-1:0]   noise_value_o,
  // register writes
  input  logic                                   cfg_we_i,
  input  logic [pn2ds_pkg::CFG_IW-1:0]           cfg_index_i,
  input  logic [pn2ds_pkg::CFG_DW-1:0]           cfg_data_i
);
  import pn2ds_pkg::*;

  localparam int unsigned NSTAGE = 11;

  localparam int unsigned PW = COORD_W + FREQ_W + 1;       // scale product
  localparam int unsigned NW = FRAC_BITS + 3;              // corner dot
  localparam int unsigned UW = FRAC_BITS + 2;              // fade weight
  localparam int unsigned DW = FRAC_BITS + 4;              // corner diff, row lerp
  localparam int unsigned XW = FRAC_BITS + 5;              // row diff, noise
  localparam int unsigned QW = XW + 1 + RANGE_W + 1;       // range product
  localparam int unsigned TW = QW + 1;                     // biased total
  localparam int unsigned RW = TW - FRAC_BITS;             // rounded magnitude

  localparam logic [FREQ_W-1:0]      FREQ_RST = FREQ_W'(64'd1 << FRAC_BITS);
  localparam logic signed [NW-1:0]   ONE_N    = NW'(1) <<< FRAC_BITS;
  localparam logic signed [XW:0]     ONE_X    = (XW+1)'(1) <<< FRAC_BITS;
  localparam logic [TW:0]            HALF_T   = (TW+1)'(1) << FRAC_BITS;
  localparam logic [RW-1:0]          POS_LIM  = RW'(NOISE_MAX);
  localparam logic [RW-1:0]          NEG_LIM  = RW'(1) << (NOISE_W - 1);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [FREQ_W-1:0]         freq_q;
  logic signed [RANGE_W-1:0] rmin_q, rmax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQ_RST;
      rmin_q <= RANGE_MIN_RST;
      rmax_q <= RANGE_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FREQUENCY: freq_q <= cfg_data_i[FREQ_W-1:0];
        CFG_RANGE_MIN: rmin_q <= $signed(cfg_data_i[RANGE_W-1:0]);
        CFG_RANGE_MAX: rmax_q <= $signed(cfg_data_i[RANGE_W-1:0]);
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage valids and load enables
  // ---------------------------------------------------------------------------
  logic [NSTAGE:1] vld_d, vld_q, en;

  always_comb begin
    en[NSTAGE] = !vld_q[NSTAGE] || !out_stall_i;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[1] = en[1] ? in_valid_i : vld_q[1];
    for (int k = 2; k <= NSTAGE; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = vld_q[NSTAGE];

  // ---------------------------------------------------------------------------
  // gradient helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [NW-1:0] grad_term(input logic signed [1:0] g,
                                                     input logic signed [NW-1:0] d);
    case (g)
      2'sb01:  return d;
      2'sb11:  return -d;
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [NW-1:0] corner_dot(input logic [HASH_W-1:0] h,
                                                      input logic signed [NW-1:0] dx,
                                                      input logic signed [NW-1:0] dy);
    return grad_term(GRAD_GX[h], dx) + grad_term(GRAD_GY[h], dy);
  endfunction

  // ---------------------------------------------------------------------------
  // stage 1: scale by frequency, split into cell hash and fraction
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0]  px, py;
  logic [HASH_W-1:0]     hs_d, hs_q;
  logic [FRAC_BITS-1:0]  fx_q, fy_q;

  always_comb begin
    px   = coord_x_i * $signed({1'b0, freq_q});
    py   = coord_y_i * $signed({1'b0, freq_q});
    // low bits of floor(px / 2^2F) plus those of floor(py / 2^2F); identity permutation
    hs_d = px[2*FRAC_BITS +: HASH_W] + py[2*FRAC_BITS +: HASH_W];
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      fx_q <= px[FRAC_BITS +: FRAC_BITS];
      fy_q <= py[FRAC_BITS +: FRAC_BITS];
      hs_q <= hs_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 2-4: fade weights (separate unit), corner dots and diffs
  // ---------------------------------------------------------------------------
  fade_en_t                  fade_en;
  logic signed [UW-1:0]      u4, v4;

  assign fade_en = '{s2: en[2], s3: en[3], s4: en[4]};

  pn2ds_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
    .clk_i  (clk_i),
    .en_i   (fade_en),
    .t_i    (fx_q),
    .fade_o (u4)
  );

  pn2ds_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
    .clk_i  (clk_i),
    .en_i   (fade_en),
    .t_i    (fy_q),
    .fade_o (v4)
  );

  logic signed [NW-1:0] dx0, dx1, dy0, dy1;
  logic signed [NW-1:0] n00_d, n10_d, n01_d, n11_d;
  logic signed [NW-1:0] n00_q, n10_q, n01_q, n11_q;

  always_comb begin
    dx0   = $signed(NW'(fx_q));
    dy0   = $signed(NW'(fy_q));
    dx1   = dx0 - ONE_N;
    dy1   = dy0 - ONE_N;
    n00_d = corner_dot(hs_q,                 dx0, dy0);
    n10_d = corner_dot(hs_q + HASH_W'(1),    dx1, dy0);
    n01_d = corner_dot(hs_q + HASH_W'(1),    dx0, dy1);
    n11_d = corner_dot(hs_q + HASH_W'(2),    dx1, dy1);
  end

  logic signed [DW-1:0] dif0_d, dif1_d, dif0_3_q, dif1_3_q, dif0_4_q, dif1_4_q;
  logic signed [NW-1:0] n00_3_q, n01_3_q, n00_4_q, n01_4_q;

  always_comb begin
    dif0_d = DW'(n10_q) - DW'(n00_q);
    dif1_d = DW'(n11_q) - DW'(n01_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      n00_q <= n00_d;
      n10_q <= n10_d;
      n01_q <= n01_d;
      n11_q <= n11_d;
    end
    if (en[3]) begin
      dif0_3_q <= dif0_d;
      dif1_3_q <= dif1_d;
      n00_3_q  <= n00_q;
      n01_3_q  <= n01_q;
    end
    if (en[4]) begin
      dif0_4_q <= dif0_3_q;
      dif1_4_q <= dif1_3_q;
      n00_4_q  <= n00_3_q;
      n01_4_q  <= n01_3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: lerp along x for both rows
  // ---------------------------------------------------------------------------
  logic signed [UW+DW-1:0] m0, m1;
  logic signed [DW-1:0]    a0_d, a1_d, a0_q, a1_q;
  logic signed [UW-1:0]    v5_q;

  always_comb begin
    m0   = u4 * dif0_4_q;
    m1   = u4 * dif1_4_q;
    a0_d = DW'(n00_4_q) + $signed(m0[FRAC_BITS +: DW]);
    a1_d = DW'(n01_4_q) + $signed(m1[FRAC_BITS +: DW]);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      a0_q <= a0_d;
      a1_q <= a1_d;
      v5_q <= v4;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 6-7: lerp along y
  // ---------------------------------------------------------------------------
  logic signed [XW-1:0]    rd_d, rd_q;
  logic signed [DW-1:0]    a0_6_q;
  logic signed [UW-1:0]    v6_q;
  logic signed [UW+XW-1:0] m2;
  logic signed [XW-1:0]    noise_d, noise_q;

  always_comb begin
    rd_d    = XW'(a1_q) - XW'(a0_q);
    m2      = v6_q * rd_q;
    noise_d = XW'(a0_6_q) + $signed(m2[FRAC_BITS +: XW]);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      rd_q   <= rd_d;
      a0_6_q <= a0_q;
      v6_q   <= v5_q;
    end
    if (en[7]) begin
      noise_q <= noise_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stages 8-9: (noise + 1) * (max - min) + 2 * min, F+1 fraction bits
  // ---------------------------------------------------------------------------
  logic signed [XW:0]        np1;
  logic signed [RANGE_W:0]   rspan;
  logic signed [QW-1:0]      prod_d, prod_q;
  logic signed [TW-1:0]      tot_d, tot_q;

  always_comb begin
    np1    = (XW+1)'(noise_q) + ONE_X;
    rspan  = (RANGE_W+1)'(rmax_q) - (RANGE_W+1)'(rmin_q);
    prod_d = np1 * rspan;
    tot_d  = TW'(prod_q) + (TW'(rmin_q) <<< (FRAC_BITS + 1));
  end

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      prod_q <= prod_d;
    end
    if (en[9]) begin
      tot_q <= tot_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 10: round half away from zero on the magnitude
  // stage 11: saturate to 16 bits (output register)
  // ---------------------------------------------------------------------------
  logic          neg_d, neg_q;
  logic [TW:0]   mag, msum;
  logic [RW-1:0] rmag_d, rmag_q;
  logic signed [NOISE_W-1:0] nv_d, nv_q;

  always_comb begin
    neg_d  = tot_q[TW-1];
    mag    = neg_d ? ((TW+1)'(0) - (TW+1)'(tot_q)) : (TW+1)'(tot_q);
    msum   = mag + HALF_T;
    rmag_d = msum[TW:FRAC_BITS+1];
  end

  always_comb begin
    if (!neg_q) begin
      nv_d = (rmag_q > POS_LIM) ? NOISE_MAX : $signed(rmag_q[NOISE_W-1:0]);
    end else begin
      nv_d = (rmag_q > NEG_LIM) ? NOISE_MIN
                                : $signed(NOISE_W'(0) - rmag_q[NOISE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      neg_q  <= neg_d;
      rmag_q <= rmag_d;
    end
    if (en[11]) begin
      nv_q <= nv_d;
    end
  end

  assign noise_value_o = nv_q;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the 2D Perlin noise core: directed table, then random points.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pn2ds_pkg::*;

  localparam int     HALF_PERIOD    = 6;
  localparam int     TIMEOUT_CYCLES = 200000;
  localparam int     PIPE_DEPTH     = 11;      // stage chain depth of the core
  localparam int     HOLD_CYCLES    = 60;      // long sink hold-off, fills every stage
  localparam int     FRAC           = FRAC_BITS_DEF;
  localparam longint ONE            = longint'(1) << FRAC;
  localparam int     SETS_PER_PHASE = 5;
  localparam int     WORDS_PER_SET  = 84;

  // index past the end of the register list, the core must drop it
  localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;

  // idle percentages per random phase: sender, then sink
  localparam int SRC_IDLE  [3] = '{33, 65, 0};
  localparam int SINK_IDLE [3] = '{65, 33, 0};

  localparam logic [31:0] COORD_EDGES [4] = '{
    32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF
  };

  // one directed word; load=1 rewrites the registers first (core drained)
  typedef struct packed {
    logic        load;
    logic [23:0] freq;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [31:0] x;
    logic [31:0] y;
    logic        known;   // want holds the hand-derived result
    logic [15:0] want;
  } probe_t;

  localparam int ROWS = 21;
  localparam probe_t PROBES [ROWS] = '{
    // reset registers: integer points land on the range midpoint
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd64},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h0001_0000, 32'h0002_0000, 1'b1, 16'd64},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'hFFFF_0000, 32'h7FFF_0000, 1'b1, 16'd64},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h0000_8000, 32'h0000_8000, 1'b0, 16'd0},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd0},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'hFFFF_FFFF, 32'h0000_FFFF, 1'b0, 16'd0},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h0003_4000, 32'hFFFD_C000, 1'b0, 16'd0},
    // zero frequency, full range: midpoint -0.5 rounds away to -1
    '{1'b1, 24'h000000, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 16'hFFFF},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h1234_5678, 32'h8765_4321, 1'b1, 16'hFFFF},
    // largest frequency
    '{1'b1, 24'hFFFFFF, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 16'd0},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h0000_1234, 32'hFFFF_A987, 1'b0, 16'd0},
    // collapsed range: output is the bound whatever the noise
    '{1'b1, 24'h010000, 16'h7FFF, 16'h7FFF, 32'h0000_4000, 32'h0000_C000, 1'b1, 16'h7FFF},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h0005_2000, 32'hFFFE_7000, 1'b1, 16'h7FFF},
    '{1'b1, 24'h010000, 16'h8000, 16'h8000, 32'h0000_4000, 32'h0000_C000, 1'b1, 16'h8000},
    // reversed range, negative scale
    '{1'b1, 24'h010000, 16'h7FFF, 16'h8000, 32'h0002_0000, 32'h0005_0000, 1'b1, 16'hFFFF},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'h0000_6000, 32'h0001_A000, 1'b0, 16'd0},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'hFFFF_2000, 32'h0000_3000, 1'b0, 16'd0},
    // fractional frequency 2.5
    '{1'b1, 24'h028000, 16'hFF00, 16'h0100, 32'h0001_3333, 32'h0002_CCCC, 1'b0, 16'd0},
    '{1'b0, 24'h0,      16'h0000, 16'h0000, 32'hFFFE_8000, 32'h0000_7FFF, 1'b0, 16'd0},
    // back to reset values
    '{1'b1, 24'h010000, 16'h0000, 16'h0080, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd64}
  };

  // clock, reset and core inputs, all known from time zero
  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic        [31:0]        coord_x   = '0;
  logic        [31:0]        coord_y   = '0;
  logic                      out_stall = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic        [CFG_IW-1:0]  cfg_index = CFG_FREQUENCY;
  logic        [CFG_DW-1:0]  cfg_data  = '0;
  logic                      in_stall;
  logic                      out_valid;
  logic signed [NOISE_W-1:0] noise_value;

  // register copy used by the predictor
  logic [23:0] freq_q = 24'h010000;
  logic [15:0] lo_q   = RANGE_MIN_RST;
  logic [15:0] hi_q   = RANGE_MAX_RST;

  logic signed [15:0] noise_expect [$];
  int                 fail_count    = 0;
  int                 src_idle_pct  = SRC_IDLE[0];
  int                 sink_idle_pct = SINK_IDLE[0];
  int                 hold_req      = 0;   // bumped by stimulus
  int                 hold_ack      = 0;   // sink side
  int                 hold_left     = 0;

  perlin_noise_2d_scaled_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .coord_x_i     (coord_x),
    .coord_y_i     (coord_y),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .noise_value_o (noise_value),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // gradients: four diagonals, then +x, -x, +y, -y
  function automatic longint grad_dot(input logic [2:0] h, input longint dx, input longint dy);
    case (h)
      3'd0:    return dx + dy;
      3'd1:    return dy - dx;
      3'd2:    return dx - dy;
      3'd3:    return -dx - dy;
      3'd4:    return dx;
      3'd5:    return -dx;
      3'd6:    return dy;
      default: return -dy;
    endcase
  endfunction

  // quintic 6t^5 - 15t^4 + 10t^3, every product floored after the shift
  function automatic longint fade_curve(input longint t);
    longint a, b, c, d;
    a = 6 * t - 15 * ONE;
    b = ((t * a) >>> FRAC) + 10 * ONE;
    c = (t * t) >>> FRAC;
    d = (c * t) >>> FRAC;
    return (d * b) >>> FRAC;
  endfunction

  function automatic longint blend(input longint t, input longint a, input longint b);
    return a + ((t * (b - a)) >>> FRAC);
  endfunction

  function automatic logic [15:0] perlin_point(input logic [31:0] x, input logic [31:0] y,
                                               input logic [23:0] freq,
                                               input logic [15:0] lo, input logic [15:0] hi);
    longint     px, py, fx, fy, u, v, a0, a1, n, total, r;
    logic [2:0] h;
    px = (longint'(signed'(x)) * longint'({1'b0, freq})) >>> FRAC;
    py = (longint'(signed'(y)) * longint'({1'b0, freq})) >>> FRAC;
    // identity permutation: corner hash is the cell sum mod 8
    h  = 3'((px >>> FRAC) + (py >>> FRAC));
    fx = px & (ONE - 1);
    fy = py & (ONE - 1);
    u  = fade_curve(fx);
    v  = fade_curve(fy);
    a0 = blend(u, grad_dot(h, fx, fy), grad_dot(h + 3'd1, fx - ONE, fy));
    a1 = blend(u, grad_dot(h + 3'd1, fx, fy - ONE), grad_dot(h + 3'd2, fx - ONE, fy - ONE));
    n  = blend(v, a0, a1);
    // F+1 fraction bits; no clip on n, only the final saturate
    total = (n + ONE) * (longint'(signed'(hi)) - longint'(signed'(lo)))
          + longint'(signed'(lo)) * 2 * ONE;
    if (total >= 0) r = (total + ONE) >>> (FRAC + 1);
    else            r = -((-total + ONE) >>> (FRAC + 1));
    if (r > 32767)       r = 32767;
    else if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0:       return $urandom;                                      // anywhere
      1, 2:    return 32'($urandom_range(2097151)) - 32'd1048576;    // within 16 cells
      3:       return {16'($urandom), 16'h0000};                      // on a corner
      4:       return {16'($urandom), {16{1'($urandom)}} ^ 16'($urandom_range(15))};
      default: return COORD_EDGES[$urandom_range(3)] ^ 32'($urandom_range(3));
    endcase
  endfunction

  function automatic logic [15:0] pick_bound();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // offer one word, wait out sender gaps and input stall, log the expectation
  task automatic push_point(input logic [31:0] x, input logic [31:0] y,
                            input logic [15:0] want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    coord_x  <= x;
    coord_y  <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    noise_expect.push_back(signed'(want));
  endtask

  // every result back means every stage is empty
  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (noise_expect.size() != 0) @(posedge clk);
  endtask

  // back-to-back writes, we stays high across them; spare index last, must be dropped
  task automatic load_regs(input logic [23:0] freq, input logic [15:0] lo,
                           input logic [15:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FREQUENCY;
    cfg_data  <= freq;
    @(posedge clk);
    cfg_index <= CFG_RANGE_MIN;
    cfg_data  <= {8'($urandom), lo};
    @(posedge clk);
    cfg_index <= CFG_RANGE_MAX;
    cfg_data  <= {8'($urandom), hi};
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_data  <= 24'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    freq_q = freq;
    lo_q   = lo;
    hi_q   = hi;
  endtask

  // ---------------------------------------------------------------- sink side

  // random stall, or a long hold-off on request so the core backs up to its input
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_ack  <= hold_ack + 1;
    end else begin
      out_stall <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  // compare each taken result word with the oldest expectation
  always @(posedge clk) begin : check_out
    logic signed [15:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (noise_expect.size() == 0) begin
        $error("noise_value: expected none, actual %0d", noise_value);
        fail_count++;
      end else begin
        want = noise_expect.pop_front();
        if (noise_value !== want) begin
          $error("noise_value: expected %0d, actual %0d", want, noise_value);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : stimulus
    logic [31:0] cx, cy;
    logic [23:0] freq;
    logic [15:0] want;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, first rows run on the reset register values
    for (int i = 0; i < ROWS; i++) begin
      if (PROBES[i].load) begin
        drain_pipe();
        load_regs(PROBES[i].freq, PROBES[i].lo, PROBES[i].hi);
      end
      want = PROBES[i].known ? PROBES[i].want
                             : perlin_point(PROBES[i].x, PROBES[i].y, freq_q, lo_q, hi_q);
      push_point(PROBES[i].x, PROBES[i].y, want);
    end

    // random phases, each with its own idle mix and several register settings
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct  <= SRC_IDLE[ph];
      sink_idle_pct <= SINK_IDLE[ph];
      for (int s = 0; s < SETS_PER_PHASE; s++) begin
        drain_pipe();
        case ($urandom_range(5))
          0:       freq = 24'h000000;
          1:       freq = 24'hFFFFFF;
          2:       freq = 24'h010000;
          3:       freq = 24'($urandom_range(24'h040000));   // up to 4.0
          default: freq = 24'($urandom);
        endcase
        load_regs(freq, pick_bound(), pick_bound());
        // long sink hold-off while words keep coming
        if (s == 0) hold_req <= hold_req + 1;
        repeat (WORDS_PER_SET) begin
          cx = pick_coord();
          cy = pick_coord();
          push_point(cx, cy, perlin_point(cx, cy, freq_q, lo_q, hi_q));
        end
      end
    end

    drain_pipe();
    // catch any stray word past the last expected one
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule
